// ===== sv/swfr_pkg.sv =====
// shared types and constants of the stop-and-wait frame receiver
package swfr_pkg;

    localparam int SWFR_PAYLOAD_BYTES = 31;

    localparam int BYTE_W      = 8;
    localparam int SIZE_W      = 16;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // flags byte layout
    localparam int SEQ_POS       = 5;
    localparam int CHUNK_END_POS = 6;
    localparam int XFER_END_POS  = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SEG_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_PATTERN   = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CHUNK = 2'd1,
        KIND_ACK   = 2'd2
    } out_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FETCH_LO,
        ST_DATA,
        ST_CHUNK,
        ST_ACK
    } state_t;

    // what the first store read after a flags beat is for
    typedef enum logic [1:0] {
        FETCH_NONE,
        FETCH_PRIOR,
        FETCH_FINAL_ONE,
        FETCH_FINAL_LONG
    } fetch_t;

endpackage

// ===== sv/stop_wait_frame_receiver_top.sv =====
// stop-and-wait frame receiver: config registers, frame store and sequencer
//
// s_ channel: one beat per decoded frame byte, PAYLOAD_BYTES payload bytes then
// the flags byte (length, sequence bit, end of chunk, end of transfer);
// s_frame_bad is looked at on the flags beat only.
// m_ channel: result beats, kind 0 payload byte, 1 chunk boundary with size,
// 2 acknowledgment; m_last_of_run marks the last beat caused by a flags beat.
// cfg channel: index 0 full_seg_size, index 1 ack_pattern, always ready; it is to be
// written by the user only while the block is idle; the block does not enforce it.
// A payload beat is written to the store and gives no result. After its flags beat
// a taken frame holds s_ready low for up to two store reads of the prior byte or
// the size bytes, the delivery of its payload bytes (one store read per byte
// through the single read port), then its boundary beat, if any, and its
// acknowledgment beat. A bad or out-of-order frame gives only its acknowledgment.
// Results leave through one output register; the next frame's bytes are
// accepted while the acknowledgment still waits there. A stalled m_ready
// holds the sequencer, and s_ready stays low until the frame's results are
// all in the output register.
// Reset clears sequence, position and done state; the store needs no clear.
// After the closing acknowledgment all further beats are taken and dropped.
module stop_wait_frame_receiver_top
    import swfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = SWFR_PAYLOAD_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_frame_byte,
    input  logic                  s_frame_bad,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_out_kind,
    output logic [BYTE_W-1:0]     m_data_byte,
    output logic [SIZE_W-1:0]     m_seg_size,
    output logic [BYTE_W-1:0]     m_ack_byte,
    output logic                  m_transfer_done,
    output logic                  m_last_of_run,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);

    logic [SIZE_W-1:0] full_seg_size_reg, full_seg_size_next;
    logic [BYTE_W-1:0] ack_pattern_reg, ack_pattern_next;

    logic              mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
    logic [BYTE_W-1:0] mem_wr_data, mem_rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        full_seg_size_next = full_seg_size_reg;
        ack_pattern_next   = ack_pattern_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FULL_SEG_SIZE: full_seg_size_next = cfg_data[SIZE_W-1:0];
                CFG_ACK_PATTERN:   ack_pattern_next   = cfg_data[BYTE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_seg_size_reg <= '0;
            ack_pattern_reg   <= '0;
        end else begin
            full_seg_size_reg <= full_seg_size_next;
            ack_pattern_reg   <= ack_pattern_next;
        end
    end

    swfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    swfr_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_byte    (s_frame_byte),
        .s_frame_bad     (s_frame_bad),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_data_byte     (m_data_byte),
        .m_seg_size      (m_seg_size),
        .m_ack_byte      (m_ack_byte),
        .m_transfer_done (m_transfer_done),
        .m_last_of_run   (m_last_of_run),
        .full_seg_size   (full_seg_size_reg),
        .ack_pattern     (ack_pattern_reg),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data)
    );

endmodule

// ===== sv/swfr_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module swfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/swfr_core.sv =====
// frame sequencer: store writes, flags decode, delivery reads and result register
module swfr_core
    import swfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = SWFR_PAYLOAD_BYTES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [BYTE_W-1:0]                s_frame_byte,
    input  logic                             s_frame_bad,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_out_kind,
    output logic [BYTE_W-1:0]                m_data_byte,
    output logic [SIZE_W-1:0]                m_seg_size,
    output logic [BYTE_W-1:0]                m_ack_byte,
    output logic                             m_transfer_done,
    output logic                             m_last_of_run,
    input  logic [SIZE_W-1:0]                full_seg_size,
    input  logic [BYTE_W-1:0]                ack_pattern,
    output logic                             mem_wr_en,
    output logic [$clog2(PAYLOAD_BYTES)-1:0] mem_wr_addr,
    output logic [BYTE_W-1:0]                mem_wr_data,
    output logic                             mem_rd_en,
    output logic [$clog2(PAYLOAD_BYTES)-1:0] mem_rd_addr,
    input  logic [BYTE_W-1:0]                mem_rd_data
);

    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
    localparam int POS_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] P_POS = POS_W'(PAYLOAD_BYTES);

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                seq_reg, seq_next;
    logic                done_reg, done_next;
    logic [BYTE_W-1:0]   prior_reg, prior_next;
    logic [POS_W-1:0]    deliver_reg, deliver_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic                boundary_reg, boundary_next;
    logic                final_reg, final_next;
    fetch_t              fetch_reg, fetch_next;
    logic [ADDR_W-1:0]   lo_addr_reg, lo_addr_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic                rd_pend_reg, rd_pend_next;

    logic                m_valid_reg, m_valid_next;
    out_kind_t           kind_reg, kind_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic [SIZE_W-1:0]   osize_reg, osize_next;
    logic [BYTE_W-1:0]   ack_reg, ack_next;
    logic                tdone_reg, tdone_next;
    logic                last_reg, last_next;

    // flags decode
    logic [LEN_W-1:0]    len_raw;
    logic [POS_W-1:0]    len_clip, len_m1, len_m2;
    logic                is_flags, frame_ok, chunk_end, xfer_end;
    fetch_t              fetch_d;
    logic [POS_W-1:0]    deliver_d;
    logic [ADDR_W-1:0]   acc_addr;
    logic [SIZE_W-1:0]   size_d;

    // control
    logic                out_free, load_beat, issue, data_done;
    out_kind_t           beat_kind;
    logic [BYTE_W-1:0]   beat_data, beat_ack;
    logic [SIZE_W-1:0]   beat_size;
    logic                beat_done, beat_last;
    logic                flags_fire, payload_fire;

    assign len_raw   = s_frame_byte[LEN_W-1:0];
    assign len_clip  = (len_raw > LEN_W'(PAYLOAD_BYTES)) ? P_POS : len_raw[POS_W-1:0];
    assign len_m1    = len_clip - POS_W'(1);
    assign len_m2    = len_clip - POS_W'(2);
    assign is_flags  = (pos_reg == P_POS);
    assign frame_ok  = !s_frame_bad && (s_frame_byte[SEQ_POS] == seq_reg);
    assign chunk_end = s_frame_byte[CHUNK_END_POS];
    assign xfer_end  = s_frame_byte[XFER_END_POS];

    always_comb begin
        fetch_d   = FETCH_NONE;
        deliver_d = len_clip;
        acc_addr  = '0;
        size_d    = full_seg_size;
        if (chunk_end && xfer_end) begin
            // final frame: size comes from the tail of the payload or the prior frame
            if (len_clip >= POS_W'(2)) begin
                fetch_d   = FETCH_FINAL_LONG;
                deliver_d = len_m2;
                acc_addr  = len_m2[ADDR_W-1:0];
            end else if (len_clip == POS_W'(1)) begin
                fetch_d   = FETCH_FINAL_ONE;
                deliver_d = '0;
            end else begin
                deliver_d = '0;
                size_d    = {{(SIZE_W-BYTE_W){1'b0}}, prior_reg};
            end
        end else if (!chunk_end && len_clip != '0) begin
            fetch_d  = FETCH_PRIOR;
            acc_addr = len_m1[ADDR_W-1:0];
        end
    end

    assign out_free     = !m_valid_reg || m_ready;
    assign data_done    = (idx_reg == deliver_reg) && !rd_pend_reg;
    assign flags_fire   = (state_reg == ST_IDLE) && s_valid && !done_reg && is_flags;
    assign payload_fire = (state_reg == ST_IDLE) && s_valid && !done_reg && !is_flags;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (flags_fire) begin
                    priority if (!frame_ok)              state_next = ST_ACK;
                    else if (fetch_d != FETCH_NONE)      state_next = ST_FETCH;
                    else                                 state_next = ST_DATA;
                end
            end
            ST_FETCH: begin
                state_next = (fetch_reg == FETCH_FINAL_LONG) ? ST_FETCH_LO : ST_DATA;
            end
            ST_FETCH_LO: begin
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (data_done) begin
                    state_next = boundary_reg ? ST_CHUNK : ST_ACK;
                end
            end
            ST_CHUNK: begin
                if (out_free) begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_ready     = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        issue       = 1'b0;
        load_beat   = 1'b0;
        beat_kind   = KIND_ACK;
        beat_data   = '0;
        beat_size   = '0;
        beat_ack    = '0;
        beat_done   = 1'b0;
        beat_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (flags_fire && frame_ok && fetch_d != FETCH_NONE) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = acc_addr;
                end
            end
            ST_FETCH: begin
                if (fetch_reg == FETCH_FINAL_LONG) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = lo_addr_reg;
                end
            end
            ST_FETCH_LO: begin
            end
            ST_DATA: begin
                // a read is issued when no read is pending or the pending one is taken this cycle
                load_beat = rd_pend_reg && out_free;
                beat_kind = KIND_DATA;
                beat_data = mem_rd_data;
                issue     = (idx_reg != deliver_reg) && (!rd_pend_reg || load_beat);
                mem_rd_en   = issue;
                mem_rd_addr = idx_reg[ADDR_W-1:0];
            end
            ST_CHUNK: begin
                load_beat = out_free;
                beat_kind = KIND_CHUNK;
                beat_size = size_reg;
            end
            ST_ACK: begin
                load_beat = out_free;
                beat_kind = KIND_ACK;
                beat_ack  = {ack_pattern[BYTE_W-1:1], ack_pattern[0] | seq_reg};
                beat_done = final_reg;
                beat_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign mem_wr_en   = payload_fire;
    assign mem_wr_addr = pos_reg[ADDR_W-1:0];
    assign mem_wr_data = s_frame_byte;

    // datapath next values
    always_comb begin
        pos_next      = pos_reg;
        seq_next      = seq_reg;
        done_next     = done_reg;
        prior_next    = prior_reg;
        deliver_next  = deliver_reg;
        idx_next      = idx_reg;
        boundary_next = boundary_reg;
        final_next    = final_reg;
        fetch_next    = fetch_reg;
        lo_addr_next  = lo_addr_reg;
        size_next     = size_reg;
        rd_pend_next  = rd_pend_reg;

        if (payload_fire) begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (flags_fire) begin
            pos_next     = '0;
            idx_next     = '0;
            rd_pend_next = 1'b0;
            lo_addr_next = len_m1[ADDR_W-1:0];
            size_next    = size_d;
            if (frame_ok) begin
                seq_next      = !seq_reg;
                deliver_next  = deliver_d;
                boundary_next = chunk_end;
                final_next    = chunk_end && xfer_end;
                fetch_next    = fetch_d;
            end else begin
                deliver_next  = '0;
                boundary_next = 1'b0;
                final_next    = 1'b0;
                fetch_next    = FETCH_NONE;
            end
        end

        if (state_reg == ST_FETCH) begin
            unique case (fetch_reg)
                FETCH_FINAL_LONG: size_next = {mem_rd_data, size_reg[BYTE_W-1:0]};
                FETCH_FINAL_ONE:  size_next = {prior_reg, mem_rd_data};
                FETCH_PRIOR:      prior_next = mem_rd_data;
                FETCH_NONE:       size_next = size_reg;
            endcase
        end
        if (state_reg == ST_FETCH_LO) begin
            size_next = {size_reg[SIZE_W-1:BYTE_W], mem_rd_data};
        end

        if (state_reg == ST_DATA) begin
            if (issue) begin
                idx_next = idx_reg + POS_W'(1);
            end
            rd_pend_next = issue || (rd_pend_reg && !load_beat);
        end

        if (state_reg == ST_ACK && out_free) begin
            done_next = final_reg;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        data_next    = data_reg;
        osize_next   = osize_reg;
        ack_next     = ack_reg;
        tdone_next   = tdone_reg;
        last_next    = last_reg;
        if (load_beat) begin
            m_valid_next = 1'b1;
            kind_next    = beat_kind;
            data_next    = beat_data;
            osize_next   = beat_size;
            ack_next     = beat_ack;
            tdone_next   = beat_done;
            last_next    = beat_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            seq_reg      <= 1'b0;
            done_reg     <= 1'b0;
            prior_reg    <= '0;
            deliver_reg  <= '0;
            idx_reg      <= '0;
            boundary_reg <= 1'b0;
            final_reg    <= 1'b0;
            fetch_reg    <= FETCH_NONE;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            seq_reg      <= seq_next;
            done_reg     <= done_next;
            prior_reg    <= prior_next;
            deliver_reg  <= deliver_next;
            idx_reg      <= idx_next;
            boundary_reg <= boundary_next;
            final_reg    <= final_next;
            fetch_reg    <= fetch_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_addr_reg <= lo_addr_next;
        size_reg    <= size_next;
        kind_reg    <= kind_next;
        data_reg    <= data_next;
        osize_reg   <= osize_next;
        ack_reg     <= ack_next;
        tdone_reg   <= tdone_next;
        last_reg    <= last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_kind      = kind_reg;
    assign m_data_byte     = data_reg;
    assign m_seg_size      = osize_reg;
    assign m_ack_byte      = ack_reg;
    assign m_transfer_done = tdone_reg;
    assign m_last_of_run   = last_reg;

endmodule

// ===== test/tb_stop_wait_frame_receiver_top.sv =====
`timescale 1ns / 100ps
// testbench of the stop-and-wait frame receiver: directed frames, random frames, beat-level check
module tb_stop_wait_frame_receiver_top;
    import swfr_pkg::*;

    localparam int NPAY          = SWFR_PAYLOAD_BYTES;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        out_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] ack;
        logic              done;
        logic              last;
    } beat_t;

    typedef enum {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RAND} fill_t;

    typedef struct {
        fill_t             fill;
        logic [BYTE_W-1:0] flags;
        logic              bad;
        logic              typed;
        logic [BYTE_W-1:0] ack;
    } frame_row_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_frame_byte = '0;
    logic                  s_frame_bad  = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [1:0]            m_out_kind;
    logic [BYTE_W-1:0]     m_data_byte;
    logic [SIZE_W-1:0]     m_seg_size;
    logic [BYTE_W-1:0]     m_ack_byte;
    logic                  m_transfer_done;
    logic                  m_last_of_run;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // receiver state mirror
    logic [BYTE_W-1:0] rx_store [NPAY] = '{default: '0};
    int unsigned       fill_pos      = 0;
    logic              want_seq      = 1'b0;
    logic [BYTE_W-1:0] prior_byte    = '0;
    logic              xfer_closed   = 1'b0;
    logic [SIZE_W-1:0] full_size_reg = '0;
    logic [BYTE_W-1:0] ack_bits_reg  = '0;
    beat_t             owed_beats [$];

    logic quiet      = 1'b0;
    int   gap_pct    = 15;
    int   stall_pct  = 10;
    int   stall_left = 0;
    int   cycles     = 0;
    int   fail_count = 0;
    int   bytes_sent = 0;
    int   beats_seen = 0;
    int   frames_taken = 0;
    int   closing_len  = 0;

    // typed acks are for frames that are only acknowledged
    frame_row_t dir_rows [4] = '{
        '{FILL_ZERO, 8'h00, 1'b1, 1'b1, 8'hFE},
        '{FILL_ONES, 8'h20, 1'b0, 1'b1, 8'hFE},
        '{FILL_RAMP, 8'h1F, 1'b0, 1'b0, 8'h00},
        '{FILL_RAMP, 8'h65, 1'b0, 1'b0, 8'h00}
    };

    stop_wait_frame_receiver_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_byte    (s_frame_byte),
        .s_frame_bad     (s_frame_bad),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_data_byte     (m_data_byte),
        .m_seg_size      (m_seg_size),
        .m_ack_byte      (m_ack_byte),
        .m_transfer_done (m_transfer_done),
        .m_last_of_run   (m_last_of_run),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void owe(out_kind_t kind, logic [BYTE_W-1:0] data,
                                logic [SIZE_W-1:0] size, logic [BYTE_W-1:0] ack,
                                logic done);
        beat_t b;
        b.kind = kind;
        b.data = data;
        b.size = size;
        b.ack  = ack;
        b.done = done;
        b.last = 1'b0;
        owed_beats.push_back(b);
    endfunction

    // stores a payload byte or resolves a frame on its flags byte; returns beats owed
    function automatic int absorb_frame_byte(logic [BYTE_W-1:0] b, logic bad);
        int unsigned       len;
        int unsigned       deliver;
        logic [SIZE_W-1:0] size;
        logic              boundary;
        logic              done;
        int                n0;
        if (xfer_closed) return 0;
        if (fill_pos < NPAY) begin
            rx_store[fill_pos] = b;
            fill_pos++;
            return 0;
        end
        fill_pos = 0;
        n0       = owed_beats.size();
        size     = '0;
        boundary = 1'b0;
        done     = 1'b0;
        if (!bad && b[SEQ_POS] == want_seq) begin
            frames_taken++;
            len = b[LEN_W-1:0];
            if (len > NPAY) len = NPAY;
            deliver  = len;
            want_seq = ~want_seq;
            if (b[CHUNK_END_POS]) begin
                boundary = 1'b1;
                if (b[XFER_END_POS]) begin
                    // closing frame: size comes from the tail of the frame or the prior frame's byte
                    done    = 1'b1;
                    deliver = 0;
                    if (len >= 2) begin
                        size    = {rx_store[len-2], rx_store[len-1]};
                        deliver = len - 2;
                    end else if (len == 1) begin
                        size = {prior_byte, rx_store[0]};
                    end else begin
                        size = {8'h00, prior_byte};
                    end
                end else begin
                    size = full_size_reg;
                end
            end else if (len > 0) begin
                prior_byte = rx_store[len-1];
            end
            for (int i = 0; i < deliver; i++) owe(KIND_DATA, rx_store[i], '0, '0, 1'b0);
            if (boundary) owe(KIND_CHUNK, '0, size, '0, 1'b0);
        end
        owe(KIND_ACK, '0, '0, ack_bits_reg | {7'd0, want_seq}, done);
        owed_beats[owed_beats.size()-1].last = 1'b1;
        if (done) xfer_closed = 1'b1;
        return owed_beats.size() - n0;
    endfunction

    task automatic send_byte(logic [BYTE_W-1:0] b, logic bad, output int owed);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < gap_pct) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= b;
        s_frame_bad  <= bad;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        owed = absorb_frame_byte(b, bad);
    endtask

    task automatic send_frame(fill_t fill, logic [BYTE_W-1:0] flags, logic bad,
                              logic typed, logic [BYTE_W-1:0] ack);
        logic [BYTE_W-1:0] pb;
        int                owed;
        beat_t             t;
        if (!quiet) begin
            gap_pct   <= ($urandom_range(2) == 0) ? 0 : 15;
            stall_pct <= ($urandom_range(2) == 0) ? 0 : 12;
        end
        for (int i = 0; i < NPAY; i++) begin
            case (fill)
                FILL_ZERO: pb = 8'h00;
                FILL_ONES: pb = 8'hFF;
                FILL_RAMP: pb = 8'(i * 8 + 3);
                default:   pb = 8'($urandom);
            endcase
            send_byte(pb, 1'($urandom), owed);
        end
        send_byte(flags, bad, owed);
        if (typed) begin
            repeat (owed) void'(owed_beats.pop_back());
            t = '{KIND_ACK, '0, '0, ack, 1'b0, 1'b1};
            owed_beats.push_back(t);
        end
    endtask

    task automatic send_random_frame();
        logic [BYTE_W-1:0] flags;
        logic              bad;
        flags = 8'($urandom);
        bad   = ($urandom_range(7) == 0);
        if ($urandom_range(3) != 0) flags[SEQ_POS] = want_seq;
        // a clean closing frame would end the transfer early
        if (!bad && flags[SEQ_POS] == want_seq && flags[CHUNK_END_POS] && flags[XFER_END_POS]) begin
            if ($urandom_range(1) == 0) flags[XFER_END_POS] = 1'b0;
            else bad = 1'b1;
        end
        send_frame(FILL_RAND, flags, bad, 1'b0, '0);
    endtask

    task automatic load_regs(logic [SIZE_W-1:0] full, logic [BYTE_W-1:0] ack);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FULL_SEG_SIZE;
        cfg_data  <= full;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        full_size_reg = full;
        cfg_index <= CFG_ACK_PATTERN;
        cfg_data  <= {8'h00, ack};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ack_bits_reg = ack;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void check_field(string name, logic [SIZE_W-1:0] want,
                                        logic [SIZE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else if (!quiet && aresetn && $urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(1, 13);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        beat_t w;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (owed_beats.size() == 0) begin
                $error("result beat with nothing outstanding: kind %0d", m_out_kind);
                fail_count++;
            end else begin
                w = owed_beats.pop_front();
                check_field("out_kind", 16'(w.kind), 16'(m_out_kind));
                check_field("data_byte", 16'(w.data), 16'(m_data_byte));
                check_field("seg_size", w.size, m_seg_size);
                check_field("ack_byte", 16'(w.ack), 16'(m_ack_byte));
                check_field("transfer_done", 16'(w.done), 16'(m_transfer_done));
                check_field("last_of_run", 16'(w.last), 16'(m_last_of_run));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, owed_beats.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] flags;
        int                owed;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_regs(16'hFFFF, 8'hFE);
        foreach (dir_rows[r]) begin
            send_frame(dir_rows[r].fill, dir_rows[r].flags, dir_rows[r].bad,
                       dir_rows[r].typed, dir_rows[r].ack);
        end

        // every phase starts from an empty pipe so the registers can change
        for (int ph = 0; ph < 2; ph++) begin
            drain_and_settle();
            case (ph)
                0: load_regs(16'($urandom), 8'($urandom_range(126) * 2 + 1));
                default: begin
                    quiet <= 1'b1;
                    load_regs(16'($urandom), 8'($urandom_range(254)));
                end
            endcase
            send_random_frame();
        end

        // closing frame, one length class per run
        case ($urandom_range(3))
            0:       closing_len = 0;
            1:       closing_len = 1;
            2:       closing_len = 2;
            default: closing_len = $urandom_range(3, NPAY);
        endcase
        flags                = '0;
        flags[LEN_W-1:0]     = LEN_W'(closing_len);
        flags[SEQ_POS]       = want_seq;
        flags[CHUNK_END_POS] = 1'b1;
        flags[XFER_END_POS]  = 1'b1;
        send_frame(FILL_RAND, flags, 1'b0, 1'b0, '0);

        // beats after the closing ack must be dropped without results
        repeat (4) send_byte(8'($urandom), 1'($urandom), owed);
        drain_and_settle();

        $display("summary: %0d bytes in, %0d frames taken, %0d result beats checked",
                 bytes_sent, frames_taken, beats_seen);
        $display("summary: three register settings, closing frame length %0d, %0d mismatches",
                 closing_len, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/swfr_pkg.sv
sv/swfr_ram.sv
sv/swfr_core.sv
sv/stop_wait_frame_receiver_top.sv
test/tb_stop_wait_frame_receiver_top.sv
